[hw/rtl/touch_key_frame_decoder_unit_assert.svh]
// ----------------------------------------------------------------------------
// Touch/key frame decoder assertion macros
// Concurrent check wrappers shared by the queue and event sequencer modules; empty when SYNTH.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_FRAME_DECODER_UNIT_ASSERT_SVH
`define TOUCH_KEY_FRAME_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Check that is skipped while reset is asserted
`define TKFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tkfd assertion failed");

// Check that also holds during reset
`define TKFD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("tkfd assertion failed");

`else

`define TKFD_ASSERT(lbl, clk, rstn, prop)
`define TKFD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hw/rtl/tkfd_pkg.sv]
// ----------------------------------------------------------------------------
// Touch/key frame decoder package
// Shared constants, frame descriptor type and event decode function.
// ----------------------------------------------------------------------------
package tkfd_pkg;

  // Window geometry
  localparam int unsigned TKFD_HELD        = 5;
  localparam int unsigned TKFD_FILL_W      = 3;
  localparam int unsigned TKFD_QUEUE_DEPTH = 2;

  // Frame headers
  localparam logic [7:0] HDR_PRESS_A = 8'h61;
  localparam logic [7:0] HDR_PRESS_B = 8'ha1;
  localparam logic [7:0] HDR_RELEASE = 8'he1;
  localparam logic [7:0] HDR_KEY_A   = 8'h51;
  localparam logic [7:0] HDR_KEY_B   = 8'h91;
  localparam logic [7:0] HDR_KEY_C   = 8'hd1;

  // Event kinds
  localparam logic [2:0] KIND_X        = 3'd0;
  localparam logic [2:0] KIND_Y        = 3'd1;
  localparam logic [2:0] KIND_PRESSURE = 3'd2;
  localparam logic [2:0] KIND_SYNC     = 3'd3;
  localparam logic [2:0] KIND_KEY      = 3'd4;

  localparam logic [15:0] PRESS_LEVEL = 16'h0FFF;

  typedef enum logic [1:0] {
    CLS_PRESS,
    CLS_RELEASE,
    CLS_KEY
  } frame_cls_e;

  // Decoded frame handed from front to back
  typedef struct packed {
    frame_cls_e cls;
    logic [7:0] header;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } frame_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] value;
    logic [7:0]  header;
    logic        last;
  } event_t;

  // Event number idx of a decoded frame
  function automatic event_t tkfd_event(frame_t fr, logic [1:0] idx);
    event_t ev;
    ev.header = fr.header;
    ev.kind   = KIND_SYNC;
    ev.value  = 16'h0000;
    ev.last   = 1'b1;
    case (fr.cls)
      CLS_PRESS: begin
        case (idx)
          2'd0: begin
            ev.kind  = KIND_X;
            ev.value = {fr.b2, fr.b1};
            ev.last  = 1'b0;
          end
          2'd1: begin
            ev.kind  = KIND_Y;
            ev.value = {fr.b4, fr.b3};
            ev.last  = 1'b0;
          end
          2'd2: begin
            ev.kind  = KIND_PRESSURE;
            ev.value = PRESS_LEVEL;
            ev.last  = 1'b0;
          end
          default: begin
            ev.kind = KIND_SYNC;
          end
        endcase
      end
      CLS_RELEASE: begin
        if (idx == 2'd0) begin
          ev.kind = KIND_PRESSURE;
          ev.last = 1'b0;
        end
      end
      default: begin
        ev.kind  = KIND_KEY;
        ev.value = {8'h00, fr.b2};
      end
    endcase
    return ev;
  endfunction

endpackage

[hw/rtl/tkfd_front.sv]
// ----------------------------------------------------------------------------
// Touch/key frame decoder front end
// Holds the byte window, checks checksum and header, emits frame descriptors.
// ----------------------------------------------------------------------------
module tkfd_front
  import tkfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       full_i,
  output logic       rx_stall_o,
  output logic       push_o,
  output frame_t     push_data_o
);

  logic [7:0]             win_q [TKFD_HELD];
  logic [7:0]             win_d [TKFD_HELD];
  logic [TKFD_FILL_W-1:0] fill_q, fill_d;
  logic                   accept;
  logic                   is_full_win;
  logic [7:0]             sum;
  logic                   csum_ok;
  logic                   hdr_known;
  logic                   is_frame;
  frame_cls_e             cls;

  // Hold off bytes while the descriptor queue has no room
  assign rx_stall_o = full_i;
  assign accept     = rx_valid_i && !full_i;
  assign is_full_win = (fill_q >= TKFD_FILL_W'(TKFD_HELD));

  // Checksum and header classification
  assign sum     = win_q[0] + win_q[1] + win_q[2] + win_q[3] + win_q[4];
  assign csum_ok = (~sum == rx_byte_i);

  always_comb begin
    hdr_known = 1'b1;
    cls       = CLS_KEY;
    if (win_q[0] inside {HDR_PRESS_A, HDR_PRESS_B}) begin
      cls = CLS_PRESS;
    end else if (win_q[0] == HDR_RELEASE) begin
      cls = CLS_RELEASE;
    end else if (win_q[0] inside {HDR_KEY_A, HDR_KEY_B, HDR_KEY_C}) begin
      cls = CLS_KEY;
    end else begin
      hdr_known = 1'b0;
    end
  end

  assign is_frame = is_full_win && csum_ok && hdr_known;
  assign push_o   = accept && is_frame;

  always_comb begin
    push_data_o.cls    = cls;
    push_data_o.header = win_q[0];
    push_data_o.b1     = win_q[1];
    push_data_o.b2     = win_q[2];
    push_data_o.b3     = win_q[3];
    push_data_o.b4     = win_q[4];
  end

  // Window update: fill, slide by one, or restart after a frame
  always_comb begin
    fill_d = fill_q;
    for (int i = 0; i < TKFD_HELD; i++) begin
      win_d[i] = win_q[i];
    end
    if (accept) begin
      if (!is_full_win) begin
        for (int i = 0; i < TKFD_HELD; i++) begin
          if (fill_q == TKFD_FILL_W'(i)) begin
            win_d[i] = rx_byte_i;
          end
        end
        fill_d = fill_q + TKFD_FILL_W'(1);
      end else if (is_frame) begin
        fill_d = '0;
      end else begin
        for (int i = 0; i < TKFD_HELD - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[TKFD_HELD-1] = rx_byte_i;
        fill_d = TKFD_FILL_W'(TKFD_HELD);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TKFD_HELD; i++) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

[hw/rtl/tkfd_queue.sv]
// ----------------------------------------------------------------------------
// Touch/key frame decoder descriptor queue
// Small register FIFO between the front end and the event sequencer.
// ----------------------------------------------------------------------------
`include "touch_key_frame_decoder_unit_assert.svh"

module tkfd_queue
  import tkfd_pkg::*;
#(
  parameter int unsigned Depth = TKFD_QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TKFD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(Depth))
  `TKFD_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && full_o))
  `TKFD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> cnt_q == '0)

endmodule

[hw/rtl/tkfd_back.sv]
// ----------------------------------------------------------------------------
// Touch/key frame decoder event sequencer
// Expands each decoded frame into its events through an output register.
// ----------------------------------------------------------------------------
`include "touch_key_frame_decoder_unit_assert.svh"

module tkfd_back
  import tkfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  frame_t      q_data_i,
  output logic        pop_o,
  output logic        ev_valid_o,
  input  logic        ev_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [15:0] event_value_o,
  output logic [7:0]  frame_header_o,
  output logic        last_of_frame_o
);

  frame_t     cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  event_t     out_q;
  event_t     ev;
  logic       out_free;
  logic       emit;
  logic       finish;

  // Next event of the current frame
  assign ev       = tkfd_event(cur_q, idx_q);
  assign out_free = !out_valid_q || !ev_stall_i;
  assign emit     = busy_q && out_free;
  assign finish   = emit && ev.last;
  assign pop_o    = q_valid_i && (!busy_q || finish);

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      out_q <= ev;
    end
  end

  assign ev_valid_o      = out_valid_q;
  assign event_kind_o    = out_q.kind;
  assign event_value_o   = out_q.value;
  assign frame_header_o  = out_q.header;
  assign last_of_frame_o = out_q.last;

  `TKFD_ASSERT(a_key_single, clk_i, rst_ni, busy_q && cur_q.cls == CLS_KEY |-> idx_q == 2'd0)
  `TKFD_ASSERT(a_release_two, clk_i, rst_ni,
               busy_q && cur_q.cls == CLS_RELEASE |-> idx_q <= 2'd1)
  `TKFD_ASSERT(a_emit_fills, clk_i, rst_ni, emit |=> out_valid_q)

endmodule

[hw/rtl/touch_key_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Touch/key frame decoder unit
// Decodes six-byte touch and key frames from a serial byte stream into events.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   rx      | in        | rx_valid_i / rx_stall_o | rx_byte_i
//   ev      | out       | ev_valid_o / ev_stall_i | event_kind_o, event_value_o,
//           |           |                        | frame_header_o, last_of_frame_o
//
// One byte is taken per cycle while rx is not stalled; the window check
// finishes in the accept cycle. A frame's first event goes through the queue,
// frame and output registers; its events follow one per cycle unless ev stalls.
// rx stalls only while the frame descriptor queue (QueueDepth entries) is full.
// Reset empties the window, the queue and the output register.
// ----------------------------------------------------------------------------
module touch_key_frame_decoder_unit
  import tkfd_pkg::*;
#(
  parameter int unsigned QueueDepth = TKFD_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        ev_valid_o,
  input  logic        ev_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [15:0] event_value_o,
  output logic [7:0]  frame_header_o,
  output logic        last_of_frame_o
);

  logic   q_full;
  logic   q_push;
  frame_t q_push_data;
  logic   q_pop;
  logic   q_valid;
  frame_t q_data;

  // Window and frame check
  tkfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_byte_i   (rx_byte_i),
    .full_i      (q_full),
    .rx_stall_o  (rx_stall_o),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  // Decoded frame queue
  tkfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // Event sequencer
  tkfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .pop_o           (q_pop),
    .ev_valid_o      (ev_valid_o),
    .ev_stall_i      (ev_stall_i),
    .event_kind_o    (event_kind_o),
    .event_value_o   (event_value_o),
    .frame_header_o  (frame_header_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

[tb/sv/touch_key_frame_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// Touch/key frame decoder unit testbench
// Streams serial bytes into the decoder and checks every emitted event against
// typed expectations or a behavioral window model. A short table of directed
// bytes covers press, release and key frames, a bad checksum and an unknown
// header. Random frames and noise follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module touch_key_frame_decoder_unit_tb;
  import tkfd_pkg::*;

  localparam int unsigned RAND_ITEMS   = 280;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned DIR_LEN      = 31;

  localparam event_t NO_EV = '0;

  // One directed request; expected events typed in where typed is set
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    logic [2:0] n_exp;
    event_t     e0, e1, e2, e3;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
    // press with all coordinate bits set
    '{8'h61, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hff, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hff, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hff, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hff, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'ha2, 1'b1, 3'd4,
      '{KIND_X, 16'hffff, HDR_PRESS_A, 1'b0},
      '{KIND_Y, 16'hffff, HDR_PRESS_A, 1'b0},
      '{KIND_PRESSURE, PRESS_LEVEL, HDR_PRESS_A, 1'b0},
      '{KIND_SYNC, 16'h0000, HDR_PRESS_A, 1'b1}},
    // release
    '{8'he1, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h1e, 1'b1, 3'd2,
      '{KIND_PRESSURE, 16'h0000, HDR_RELEASE, 1'b0},
      '{KIND_SYNC, 16'h0000, HDR_RELEASE, 1'b1}, NO_EV, NO_EV},
    // key frame
    '{8'h91, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hff, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h6f, 1'b1, 3'd1, '{KIND_KEY, 16'h00ff, HDR_KEY_B, 1'b1}, NO_EV, NO_EV, NO_EV},
    // known header with bad checksum, then a key frame one byte later
    '{8'h61, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hd1, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h80, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hae, 1'b0, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    // good checksum, unknown header
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'h00, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV},
    '{8'hff, 1'b1, 3'd0, NO_EV, NO_EV, NO_EV, NO_EV}
  };

  localparam logic [7:0] HDR_POOL [6] = '{
    HDR_PRESS_A, HDR_PRESS_B, HDR_RELEASE, HDR_KEY_A, HDR_KEY_B, HDR_KEY_C
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        ev_valid_o;
  logic        ev_stall_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [15:0] event_value_o;
  logic [7:0]  frame_header_o;
  logic        last_of_frame_o;

  // Model of the byte window
  logic [7:0]  held [TKFD_HELD];
  int unsigned held_cnt = 0;

  event_t      pending_events [$];
  int unsigned error_cnt = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  bit          steady = 1'b0;

  // Typed expectations that travel with the request on the wire
  bit          hold_typed = 1'b0;
  int unsigned hold_n = 0;
  event_t      hold_ev [4];

  touch_key_frame_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_stall_o      (rx_stall_o),
    .rx_byte_i       (rx_byte_i),
    .ev_valid_o      (ev_valid_o),
    .ev_stall_i      (ev_stall_i),
    .event_kind_o    (event_kind_o),
    .event_value_o   (event_value_o),
    .frame_header_o  (frame_header_o),
    .last_of_frame_o (last_of_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic event_t mk_event(logic [2:0] kind, logic [15:0] value,
                                      logic [7:0] hdr, logic last);
    event_t ev;
    ev.kind   = kind;
    ev.value  = value;
    ev.header = hdr;
    ev.last   = last;
    return ev;
  endfunction

  // Window update for one received byte; returns the events it releases
  task automatic decode_byte(input logic [7:0] b, output event_t evs [4],
                             output int unsigned n);
    logic [7:0] hdr;
    logic [7:0] acc;
    bit         known;
    n = 0;
    for (int k = 0; k < 4; k++) evs[k] = NO_EV;
    if (held_cnt < TKFD_HELD) begin
      held[held_cnt] = b;
      held_cnt++;
      return;
    end
    hdr = held[0];
    acc = 8'h00;
    for (int k = 0; k < TKFD_HELD; k++) acc = acc + held[k];
    acc = ~acc;
    known = (hdr == HDR_PRESS_A) || (hdr == HDR_PRESS_B) || (hdr == HDR_RELEASE) ||
            (hdr == HDR_KEY_A) || (hdr == HDR_KEY_B) || (hdr == HDR_KEY_C);
    if (known && acc == b) begin
      if (hdr == HDR_RELEASE) begin
        evs[0] = mk_event(KIND_PRESSURE, 16'h0000, hdr, 1'b0);
        evs[1] = mk_event(KIND_SYNC, 16'h0000, hdr, 1'b1);
        n = 2;
      end else if (hdr == HDR_PRESS_A || hdr == HDR_PRESS_B) begin
        evs[0] = mk_event(KIND_X, {held[2], held[1]}, hdr, 1'b0);
        evs[1] = mk_event(KIND_Y, {held[4], held[3]}, hdr, 1'b0);
        evs[2] = mk_event(KIND_PRESSURE, PRESS_LEVEL, hdr, 1'b0);
        evs[3] = mk_event(KIND_SYNC, 16'h0000, hdr, 1'b1);
        n = 4;
      end else begin
        evs[0] = mk_event(KIND_KEY, {8'h00, held[2]}, hdr, 1'b1);
        n = 1;
      end
      for (int k = 0; k < TKFD_HELD; k++) held[k] = 8'h00;
      held_cnt = 0;
    end else begin
      // no frame: slide by one byte
      for (int k = 0; k < TKFD_HELD - 1; k++) held[k] = held[k + 1];
      held[TKFD_HELD - 1] = b;
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("error @%0t: %s", $time, msg);
    error_cnt++;
  endtask

  task automatic check_event();
    event_t want;
    if (pending_events.size() == 0) begin
      note_mismatch($sformatf("unexpected event kind=%0d value=%h hdr=%h",
                              event_kind_o, event_value_o, frame_header_o));
      return;
    end
    want = pending_events.pop_front();
    if (event_kind_o !== want.kind)
      note_mismatch($sformatf("kind %0d, want %0d", event_kind_o, want.kind));
    if (event_value_o !== want.value)
      note_mismatch($sformatf("value %h, want %h", event_value_o, want.value));
    if (frame_header_o !== want.header)
      note_mismatch($sformatf("header %h, want %h", frame_header_o, want.header));
    if (last_of_frame_o !== want.last)
      note_mismatch($sformatf("last %0b, want %0b", last_of_frame_o, want.last));
  endtask

  // Request and event monitor, predictor runs on every accepted byte
  always @(posedge clk_i) begin
    event_t      evs [4];
    int unsigned n;
    if (rst_ni) begin
      if (ev_valid_o && !ev_stall_i) check_event();
      if (rx_valid_i && !rx_stall_o) begin
        decode_byte(rx_byte_i, evs, n);
        if (hold_typed) begin
          for (int k = 0; k < hold_n; k++) pending_events.push_back(hold_ev[k]);
        end else begin
          for (int k = 0; k < n; k++) pending_events.push_back(evs[k]);
        end
      end
    end
  end

  // Watchdog: cycles with no request and no event taken
  always @(posedge clk_i) begin
    if ((rx_valid_i && !rx_stall_o) || (ev_valid_o && !ev_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("touch_key_frame_decoder_unit: mismatch");
      $finish;
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    ev_stall_i <= !steady && ($urandom_range(99) < 19);
  end

  // Present one byte from a falling edge and return at the falling edge after it is taken
  task automatic push_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 19) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o);
    sent++;
    @(negedge clk_i);
  endtask

  // Six-byte frame with random content; bad_sum spoils the checksum
  task automatic send_frame(input logic [7:0] hdr, input bit bad_sum);
    logic [7:0] f [6];
    logic [7:0] acc;
    f[0] = hdr;
    acc  = hdr;
    for (int k = 1; k < 5; k++) begin
      f[k] = 8'($urandom_range(255));
      acc  = acc + f[k];
    end
    f[5] = ~acc;
    if (bad_sum) f[5] = f[5] ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < 6; k++) push_byte(f[k]);
  endtask

  initial begin
    int unsigned pick;
    bit          paused;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    for (int i = 0; i < DIR_LEN; i++) begin
      hold_typed = DIR_ROWS[i].typed;
      hold_n     = DIR_ROWS[i].n_exp;
      hold_ev[0] = DIR_ROWS[i].e0;
      hold_ev[1] = DIR_ROWS[i].e1;
      hold_ev[2] = DIR_ROWS[i].e2;
      hold_ev[3] = DIR_ROWS[i].e3;
      push_byte(DIR_ROWS[i].data);
    end
    hold_typed = 1'b0;

    // random frames, damaged frames and line noise
    while (sent < DIR_LEN + RAND_ITEMS) begin
      steady = (sent >= DIR_LEN + 90) && (sent < DIR_LEN + 170);
      if (!paused && sent >= DIR_LEN + 200) begin
        // hold off until every event has drained
        rx_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending_events.size() != 0);
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(HDR_POOL[$urandom_range(5)], 1'b0);
      end else if (pick < 78) begin
        send_frame(8'($urandom_range(255)), 1'b0);
      end else if (pick < 88) begin
        send_frame(HDR_POOL[$urandom_range(5)], 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
      end
    end
    steady = 1'b0;

    rx_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_events.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("touch_key_frame_decoder_unit: match");
    end else begin
      $display("touch_key_frame_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tkfd_pkg.sv
hw/rtl/tkfd_front.sv
hw/rtl/tkfd_queue.sv
hw/rtl/tkfd_back.sv
hw/rtl/touch_key_frame_decoder_unit.sv
tb/sv/touch_key_frame_decoder_unit_tb.sv
